// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/fpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared constants and types of the segment allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDRESS_BITS_DEF = 32;
    localparam int ID_BITS_DEF      = 16;

    localparam logic [63:0] MEM_SIZE_RESET = 64'h0000_0000_0001_0000;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic       REG_MEM_SIZE   = 1'b0;
    localparam logic       REG_FIT_POLICY = 1'b1;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NOFIT = 3'd1;
    localparam logic [2:0] ST_NOID  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_NOIDS = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_id;
        logic [31:0] granted_address;
        logic [31:0] used_bytes;
        logic [31:0] free_bytes;
        logic [31:0] largest_free;
    } t_result;

endpackage

// ===== sv/fpsa_if.sv =====
// ----------------------------------------------------------------------------
// fpsa_if
// Command and result channels, valid/ready words.
// ----------------------------------------------------------------------------
interface fpsa_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] request_size;
    logic [15:0] release_id;

    modport source (output valid, command, request_size, release_id, input ready);
    modport sink   (input valid, command, request_size, release_id, output ready);
endinterface

interface fpsa_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] granted_id;
    logic [31:0] granted_address;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
    logic [31:0] largest_free;

    modport source (output valid, status, granted_id, granted_address, used_bytes,
                    free_bytes, largest_free, input ready);
    modport sink   (input valid, status, granted_id, granted_address, used_bytes,
                    free_bytes, largest_free, output ready);
endinterface

// ===== sv/fpsa_table.sv =====
// ----------------------------------------------------------------------------
// fpsa_table
// Segment table memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpsa_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/fpsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpsa_ctrl
// Sequencer: fit scan, table shifts, coalescing and byte totals.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDRESS_BITS = 32,
    parameter int ID_BITS      = 16,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int EW = 2 * ADDRESS_BITS + 1 + ID_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_command,
    input  logic [31:0]             i_request_size,
    input  logic [15:0]             i_release_id,
    input  logic [ADDRESS_BITS-1:0] i_mem_size,
    input  logic [1:0]              i_policy,
    input  logic                    i_rebuild,
    input  logic                    i_out_free,
    output logic                    o_ready,
    output logic                    o_done,
    output fpsa_pkg::t_result       o_result,
    output logic                    o_wr_en,
    output logic [IW-1:0]           o_wr_addr,
    output logic [EW-1:0]           o_wr_data,
    output logic [IW-1:0]           o_rd_addr,
    input  logic [EW-1:0]           i_rd_data
);

    localparam int AB = ADDRESS_BITS;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0]      SEG_MAX  = CW'(MAX_SEGMENTS);
    localparam logic [ID_BITS:0]   ID_LIMIT = (ID_BITS+1)'(1) << ID_BITS;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WAIT, S_SCAN_CHK, S_SCAN_EV, S_SCAN_END,
        S_INS, S_INS2, S_MV_CHK, S_MV_WR, S_FREE_NX, S_FREE_NXEV,
        S_FREE_PV, S_FREE_PVEV, S_TOT_CHK, S_TOT_EV
    } t_state;

    t_state r_state, n_state, r_after, n_after, r_ret, n_ret, r_done_st, n_done_st;
    logic             r_cmd, n_cmd;
    logic [31:0]      r_size, n_size;
    logic [15:0]      r_rid, n_rid;
    logic [CW-1:0]    r_idx, n_idx, r_count, n_count, r_pick, n_pick;
    logic [CW-1:0]    r_dst, n_dst, r_mvcnt, n_mvcnt;
    logic             r_up, n_up, r_found, n_found, r_fin, n_fin;
    logic [ID_BITS:0] r_idc, n_idc;
    logic [AB-1:0]    r_pstart, n_pstart, r_plen, n_plen, r_big, n_big;
    logic [IW-1:0]    r_ra, n_ra;
    logic [2:0]       r_status, n_status;
    logic [15:0]      r_gid, n_gid;
    logic [31:0]      r_gaddr, n_gaddr, r_used, n_used, r_free, n_free;

    logic [AB-1:0]      d_start, d_len, rest;
    logic               d_free, fit, better;
    logic [ID_BITS-1:0] d_own;

    assign d_start = i_rd_data[EW-1 -: AB];
    assign d_len   = i_rd_data[EW-1-AB -: AB];
    assign d_free  = i_rd_data[ID_BITS];
    assign d_own   = i_rd_data[ID_BITS-1:0];
    assign rest    = AB'(64'(r_plen) - 64'(r_size));
    assign fit     = d_free && (64'(d_len) >= 64'(r_size));
    assign better  = !r_found
                   || ((i_policy == fpsa_pkg::FIT_BEST) && (d_len < r_plen))
                   || ((i_policy == fpsa_pkg::FIT_WORST) && (d_len > r_plen));

    assign o_ready   = (r_state == S_IDLE);
    assign o_done    = r_fin && i_out_free;
    assign o_rd_addr = r_ra;
    assign o_result  = '{status: r_status, granted_id: r_gid, granted_address: r_gaddr,
                         used_bytes: r_used, free_bytes: r_free,
                         largest_free: 32'(r_big)};

    always_comb begin
        n_state = r_state;   n_after = r_after;   n_ret = r_ret;   n_done_st = r_done_st;
        n_cmd = r_cmd;       n_size = r_size;     n_rid = r_rid;
        n_idx = r_idx;       n_count = r_count;   n_pick = r_pick;
        n_dst = r_dst;       n_mvcnt = r_mvcnt;   n_up = r_up;
        n_found = r_found;   n_fin = r_fin;       n_idc = r_idc;
        n_pstart = r_pstart; n_plen = r_plen;     n_big = r_big;
        n_ra = r_ra;         n_status = r_status; n_gid = r_gid;
        n_gaddr = r_gaddr;   n_used = r_used;     n_free = r_free;
        o_wr_en = 1'b0;
        o_wr_addr = r_pick[IW-1:0];
        o_wr_data = '0;
        case (r_state)
            S_INIT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = {AB'(0), i_mem_size, 1'b1, ID_BITS'(0)};
                n_count   = CW'(1);
                n_idc     = (ID_BITS+1)'(1);
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_command;
                    n_size   = i_request_size;
                    n_rid    = i_release_id;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = fpsa_pkg::ST_OK;
                    n_gid    = '0;
                    n_gaddr  = '0;
                    n_state  = S_SCAN_CHK;
                    if (i_command == fpsa_pkg::CMD_ALLOC) begin
                        if (r_idc[ID_BITS]) begin
                            n_status = fpsa_pkg::ST_NOIDS;
                            n_state  = S_TOT_CHK;
                        end else if (i_request_size == '0) begin
                            n_status = fpsa_pkg::ST_NOFIT;
                            n_state  = S_TOT_CHK;
                        end
                    end else if (i_release_id == '0) begin
                        n_status = fpsa_pkg::ST_NOID;
                        n_state  = S_TOT_CHK;
                    end
                    n_used = '0;
                    n_free = '0;
                    n_big  = '0;
                end
            end
            S_WAIT: begin
                n_state = r_after;
            end
            S_SCAN_CHK: begin
                if (r_idx == r_count) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_ra    = r_idx[IW-1:0];
                    n_after = S_SCAN_EV;
                    n_state = S_WAIT;
                end
            end
            S_SCAN_EV: begin
                n_idx   = r_idx + CW'(1);
                n_state = S_SCAN_CHK;
                if (r_cmd == fpsa_pkg::CMD_ALLOC) begin
                    if (fit && better) begin
                        n_found  = 1'b1;
                        n_pick   = r_idx;
                        n_pstart = d_start;
                        n_plen   = d_len;
                    end
                end else if (!d_free && (64'(d_own) == 64'(r_rid))) begin
                    n_found  = 1'b1;
                    n_pick   = r_idx;
                    n_pstart = d_start;
                    n_plen   = d_len;
                    n_state  = S_FREE_NX;
                end
            end
            S_SCAN_END: begin
                n_state = S_TOT_CHK;
                if (!r_found) begin
                    n_status = (r_cmd == fpsa_pkg::CMD_ALLOC) ? fpsa_pkg::ST_NOFIT
                                                              : fpsa_pkg::ST_NOID;
                end else if (rest != '0) begin
                    if (r_count == SEG_MAX) begin
                        n_status = fpsa_pkg::ST_FULL;
                    end else begin
                        n_up    = 1'b1;
                        n_dst   = r_count;
                        n_mvcnt = r_count - r_pick - CW'(1);
                        n_ret   = S_INS;
                        n_state = S_MV_CHK;
                    end
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_data = {r_pstart, r_plen, 1'b0, ID_BITS'(r_idc)};
                    n_gid     = 16'(r_idc);
                    n_gaddr   = 32'(r_pstart);
                    n_idc     = r_idc + (ID_BITS+1)'(1);
                end
            end
            S_INS: begin
                o_wr_en   = 1'b1;
                o_wr_addr = IW'(r_pick + CW'(1));
                o_wr_data = {AB'(64'(r_pstart) + 64'(r_size)), rest, 1'b1, ID_BITS'(0)};
                n_count   = r_count + CW'(1);
                n_state   = S_INS2;
            end
            S_INS2: begin
                o_wr_en   = 1'b1;
                o_wr_data = {r_pstart, AB'(r_size), 1'b0, ID_BITS'(r_idc)};
                n_gid     = 16'(r_idc);
                n_gaddr   = 32'(r_pstart);
                n_idc     = r_idc + (ID_BITS+1)'(1);
                n_state   = S_TOT_CHK;
            end
            S_MV_CHK: begin
                if (r_mvcnt == '0) begin
                    n_state = r_ret;
                end else begin
                    n_ra    = r_up ? IW'(r_dst - CW'(1)) : IW'(r_dst + CW'(1));
                    n_after = S_MV_WR;
                    n_state = S_WAIT;
                end
            end
            S_MV_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_dst[IW-1:0];
                o_wr_data = i_rd_data;
                n_dst     = r_up ? (r_dst - CW'(1)) : (r_dst + CW'(1));
                n_mvcnt   = r_mvcnt - CW'(1);
                n_state   = S_MV_CHK;
            end
            S_FREE_NX: begin
                if ((r_pick + CW'(1)) < r_count) begin
                    n_ra    = IW'(r_pick + CW'(1));
                    n_after = S_FREE_NXEV;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_FREE_PV;
                end
            end
            S_FREE_NXEV: begin
                n_state = S_FREE_PV;
                if (d_free) begin
                    n_plen  = AB'(64'(r_plen) + 64'(d_len));
                    n_up    = 1'b0;
                    n_dst   = r_pick + CW'(1);
                    n_mvcnt = r_count - r_pick - CW'(2);
                    n_count = r_count - CW'(1);
                    n_ret   = S_FREE_PV;
                    n_state = S_MV_CHK;
                end
            end
            S_FREE_PV: begin
                if (r_pick != '0) begin
                    n_ra    = IW'(r_pick - CW'(1));
                    n_after = S_FREE_PVEV;
                    n_state = S_WAIT;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_data = {r_pstart, r_plen, 1'b1, ID_BITS'(0)};
                    n_state   = S_TOT_CHK;
                end
            end
            S_FREE_PVEV: begin
                o_wr_en = 1'b1;
                n_state = S_TOT_CHK;
                if (d_free) begin
                    o_wr_addr = IW'(r_pick - CW'(1));
                    o_wr_data = {d_start, AB'(64'(d_len) + 64'(r_plen)), 1'b1, ID_BITS'(0)};
                    n_up      = 1'b0;
                    n_dst     = r_pick;
                    n_mvcnt   = r_count - r_pick - CW'(1);
                    n_count   = r_count - CW'(1);
                    n_ret     = S_TOT_CHK;
                    n_state   = S_MV_CHK;
                end else begin
                    o_wr_data = {r_pstart, r_plen, 1'b1, ID_BITS'(0)};
                end
            end
            S_TOT_CHK: begin
                if (n_idx == '0 && r_done_st != S_TOT_CHK) begin
                    n_idx = '0;
                end
                if (r_done_st != S_TOT_CHK) begin
                    n_done_st = S_TOT_CHK;
                    n_idx     = '0;
                    n_used    = '0;
                    n_free    = '0;
                    n_big     = '0;
                end else if (r_idx == r_count) begin
                    n_fin = 1'b1;
                    if (r_fin && i_out_free) begin
                        n_fin     = 1'b0;
                        n_done_st = S_IDLE;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_ra    = r_idx[IW-1:0];
                    n_after = S_TOT_EV;
                    n_state = S_WAIT;
                end
            end
            S_TOT_EV: begin
                if (d_free) begin
                    n_free = r_free + 32'(d_len);
                    if (d_len > r_big) begin
                        n_big = d_len;
                    end
                end else begin
                    n_used = r_used + 32'(d_len);
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_TOT_CHK;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_rebuild) begin
            n_state   = S_INIT;
            n_fin     = 1'b0;
            n_done_st = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;   r_after <= S_IDLE;  r_ret <= S_IDLE;  r_done_st <= S_IDLE;
            r_count <= CW'(1);   r_idc <= (ID_BITS+1)'(1);
            r_fin <= 1'b0;       r_found <= 1'b0;    r_up <= 1'b0;
            r_idx <= '0;         r_pick <= '0;       r_dst <= '0;      r_mvcnt <= '0;
            r_ra <= '0;          r_cmd <= 1'b0;      r_size <= '0;     r_rid <= '0;
            r_pstart <= '0;      r_plen <= '0;       r_big <= '0;      r_status <= '0;
            r_gid <= '0;         r_gaddr <= '0;      r_used <= '0;     r_free <= '0;
        end else begin
            r_state <= n_state;  r_after <= n_after; r_ret <= n_ret;   r_done_st <= n_done_st;
            r_count <= n_count;  r_idc <= n_idc;
            r_fin <= n_fin;      r_found <= n_found; r_up <= n_up;
            r_idx <= n_idx;      r_pick <= n_pick;   r_dst <= n_dst;   r_mvcnt <= n_mvcnt;
            r_ra <= n_ra;        r_cmd <= n_cmd;     r_size <= n_size; r_rid <= n_rid;
            r_pstart <= n_pstart; r_plen <= n_plen;  r_big <= n_big;   r_status <= n_status;
            r_gid <= n_gid;      r_gaddr <= n_gaddr; r_used <= n_used; r_free <= n_free;
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count != '0) && (r_count <= SEG_MAX), "segment count out of range")
    `ASSERT_ALWAYS(a_id_limit, i_clk, i_rst_n, r_idc <= ID_LIMIT, "id counter past limit")
    `ASSERT_IMPLY(a_wr_in_table, i_clk, i_rst_n, o_wr_en, CW'(o_wr_addr) <= r_count, "table write beyond fill")
    `ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done && !i_rebuild, ##1 (r_state == S_IDLE), "result without return to idle")

endmodule

// ===== sv/fit_policy_segment_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator_unit
// Segment allocator with first/best/worst fit and coalescing on free.
// ----------------------------------------------------------------------------
// Words are taken one at a time; every table access goes through the single
// registered read port of the table memory.
// Reset (synchronous, active low): one free segment of 65536 bytes, fit
// policy first fit, next id 1; the first cycle after reset writes entry 0.
module fit_policy_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDRESS_BITS = fpsa_pkg::ADDRESS_BITS_DEF,
    parameter int ID_BITS      = fpsa_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fpsa_cmd_if.sink    i_cmd,
    fpsa_res_if.source  o_res
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int EW = 2 * ADDRESS_BITS + 1 + ID_BITS;

    logic [ADDRESS_BITS-1:0] r_mem_size;
    logic [1:0]              r_policy;
    logic                    r_out_valid;
    fpsa_pkg::t_result       r_out;

    logic              cfg_wr, rebuild, out_free, start, ready, done;
    fpsa_pkg::t_result result;
    logic              wr_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [EW-1:0]     wr_data, rd_data;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign rebuild  = cfg_wr && (paddr[2] == fpsa_pkg::REG_MEM_SIZE);
    assign out_free = !r_out_valid || o_res.ready;
    assign start    = i_cmd.valid && ready;
    assign i_cmd.ready = ready;

    always_comb begin
        case (paddr[2])
            fpsa_pkg::REG_MEM_SIZE:   prdata = 32'(r_mem_size);
            fpsa_pkg::REG_FIT_POLICY: prdata = 32'(r_policy);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size  <= ADDRESS_BITS'(fpsa_pkg::MEM_SIZE_RESET);
            r_policy    <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (cfg_wr && (paddr[2] == fpsa_pkg::REG_MEM_SIZE)) begin
                r_mem_size <= ADDRESS_BITS'(pwdata);
            end
            if (cfg_wr && (paddr[2] == fpsa_pkg::REG_FIT_POLICY)) begin
                r_policy <= pwdata[1:0];
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_out       <= result;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.granted_id      = r_out.granted_id;
    assign o_res.granted_address = r_out.granted_address;
    assign o_res.used_bytes      = r_out.used_bytes;
    assign o_res.free_bytes      = r_out.free_bytes;
    assign o_res.largest_free    = r_out.largest_free;

    fpsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .ID_BITS      (ID_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_cmd.command),
        .i_request_size (i_cmd.request_size),
        .i_release_id   (i_cmd.release_id),
        .i_mem_size     (r_mem_size),
        .i_policy       (r_policy),
        .i_rebuild      (rebuild),
        .i_out_free     (out_free),
        .o_ready        (ready),
        .o_done         (done),
        .o_result       (result),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data)
    );

    fpsa_table #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== tb/fpsa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsa_tb_pkg
// Expected-result model of the segment allocator for the testbench.
// ----------------------------------------------------------------------------
package fpsa_tb_pkg;
    import fpsa_pkg::*;

    localparam int NSEG = 64;

    typedef struct {
        logic [31:0] start;
        logic [31:0] len;
        bit          is_free;
        logic [15:0] owner;
    } t_seg;

    class seg_table_model;
        t_seg        seg[NSEG];
        int          count;
        logic [16:0] next_id;
        logic [31:0] mem_size;
        logic [1:0]  policy;

        function new();
            mem_size = 32'h0001_0000;
            policy   = 2'd0;
            rebuild();
        endfunction

        function void rebuild();
            foreach (seg[i]) begin
                seg[i] = '{32'd0, 32'd0, 1'b0, 16'd0};
            end
            seg[0].len     = mem_size;
            seg[0].is_free = 1'b1;
            count          = 1;
            next_id        = 17'd1;
        endfunction

        function void write_reg(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_MEM_SIZE) begin
                mem_size = value;
                rebuild();
            end else begin
                policy = value[1:0];
            end
        endfunction

        function void drop(int pos);
            for (int i = pos; i + 1 < count; i++) seg[i] = seg[i + 1];
            count--;
            seg[count] = '{32'd0, 32'd0, 1'b0, 16'd0};
        endfunction

        function logic [2:0] allocate(logic [31:0] size, output logic [15:0] id,
                                      output logic [31:0] addr);
            int   pick;
            bit   found;
            logic [31:0] rest;
            pick  = 0;
            found = 0;
            id    = '0;
            addr  = '0;
            if (next_id > 17'hFFFF) return ST_NOIDS;
            if (size == 0) return ST_NOFIT;
            for (int i = 0; i < count; i++) begin
                if (!seg[i].is_free || seg[i].len < size) continue;
                if (!found) begin
                    pick  = i;
                    found = 1;
                    if (policy != FIT_BEST && policy != FIT_WORST) break;
                end else if (policy == FIT_BEST && seg[i].len < seg[pick].len) begin
                    pick = i;
                end else if (policy == FIT_WORST && seg[i].len > seg[pick].len) begin
                    pick = i;
                end
            end
            if (!found) return ST_NOFIT;
            rest = seg[pick].len - size;
            if (rest != 0) begin
                if (count >= NSEG) return ST_FULL;
                for (int i = count; i > pick + 1; i--) seg[i] = seg[i - 1];
                seg[pick + 1] = '{seg[pick].start + size, rest, 1'b1, 16'd0};
                count++;
                seg[pick].len = size;
            end
            seg[pick].is_free = 1'b0;
            seg[pick].owner   = next_id[15:0];
            id                = next_id[15:0];
            addr              = seg[pick].start;
            next_id++;
            return ST_OK;
        endfunction

        function logic [2:0] release_seg(logic [15:0] id);
            if (id == 0) return ST_NOID;
            for (int i = 0; i < count; i++) begin
                if (seg[i].is_free || seg[i].owner != id) continue;
                seg[i].is_free = 1'b1;
                seg[i].owner   = 16'd0;
                if (i + 1 < count && seg[i + 1].is_free) begin
                    seg[i].len = seg[i].len + seg[i + 1].len;
                    drop(i + 1);
                end
                if (i > 0 && seg[i - 1].is_free) begin
                    seg[i - 1].len = seg[i - 1].len + seg[i].len;
                    drop(i);
                end
                return ST_OK;
            end
            return ST_NOID;
        endfunction

        function t_result step(logic cmd, logic [31:0] size, logic [15:0] id);
            t_result r;
            logic [15:0] gid;
            logic [31:0] gaddr;
            gid   = '0;
            gaddr = '0;
            r     = '0;
            if (cmd == CMD_ALLOC) r.status = allocate(size, gid, gaddr);
            else r.status = release_seg(id);
            r.granted_id      = gid;
            r.granted_address = gaddr;
            for (int i = 0; i < count; i++) begin
                if (seg[i].is_free) begin
                    r.free_bytes += seg[i].len;
                    if (seg[i].len > r.largest_free) r.largest_free = seg[i].len;
                end else begin
                    r.used_bytes += seg[i].len;
                end
            end
            return r;
        endfunction

        // ids currently owned by used segments
        function void live_ids(ref logic [15:0] ids[$]);
            ids.delete();
            for (int i = 0; i < count; i++)
                if (!seg[i].is_free) ids.push_back(seg[i].owner);
        endfunction
    endclass
endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives allocate/free words and APB register writes into the allocator and
// checks every result word against an internal table model.
// ----------------------------------------------------------------------------
module tb;
    import fpsa_pkg::*;
    import fpsa_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fpsa_cmd_if cmd_if();
    fpsa_res_if res_if();

    fit_policy_segment_allocator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_cmd(cmd_if.sink), .o_res(res_if.source)
    );

    always #6 i_clk = ~i_clk;

    seg_table_model alloc_model;
    t_result        expected_words[$];
    int             error_count = 0;
    int             word_count = 0;
    int             ok_count = 0;
    bit             allow_idle = 1'b1;

    initial begin
        cmd_if.valid        = 1'b0;
        cmd_if.command      = CMD_ALLOC;
        cmd_if.request_size = '0;
        cmd_if.release_id   = '0;
        res_if.ready        = 1'b0;
    end

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got, exp_word;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.status, res_if.granted_id, res_if.granted_address,
                    res_if.used_bytes, res_if.free_bytes, res_if.largest_free};
            word_count++;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                exp_word = expected_words.pop_front();
                if (got.status == ST_OK) ok_count++;
                if (got.status !== exp_word.status) begin
                    $error("status exp %0d got %0d", exp_word.status, got.status);
                    error_count++;
                end
                if (got.granted_id !== exp_word.granted_id) begin
                    $error("granted_id exp %0d got %0d", exp_word.granted_id,
                           got.granted_id);
                    error_count++;
                end
                if (got.granted_address !== exp_word.granted_address) begin
                    $error("granted_address exp %0h got %0h", exp_word.granted_address,
                           got.granted_address);
                    error_count++;
                end
                if (got.used_bytes !== exp_word.used_bytes) begin
                    $error("used_bytes exp %0h got %0h", exp_word.used_bytes,
                           got.used_bytes);
                    error_count++;
                end
                if (got.free_bytes !== exp_word.free_bytes) begin
                    $error("free_bytes exp %0h got %0h", exp_word.free_bytes,
                           got.free_bytes);
                    error_count++;
                end
                if (got.largest_free !== exp_word.largest_free) begin
                    $error("largest_free exp %0h got %0h", exp_word.largest_free,
                           got.largest_free);
                    error_count++;
                end
            end
        end
    end

    // valid stays up between back-to-back words; idle gaps and drain drop it
    task automatic send_word(logic cmd, logic [31:0] size, logic [15:0] id);
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= cmd;
        cmd_if.request_size <= size;
        cmd_if.release_id   <= id;
        do @(posedge i_clk); while (!cmd_if.ready);
        expected_words.push_back(alloc_model.step(cmd, size, id));
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic reg_write(logic reg_idx, logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_idx ? 3'd4 : 3'd0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        alloc_model.write_reg(reg_idx, value);
    endtask

    task automatic free_random_live();
        logic [15:0] ids[$];
        alloc_model.live_ids(ids);
        if (ids.size() == 0) send_word(CMD_FREE, $urandom, $urandom_range(1, 65535));
        else send_word(CMD_FREE, $urandom, ids[$urandom_range(0, ids.size() - 1)]);
    endtask

    task automatic test_directed();
        send_word(CMD_ALLOC, 32'd0, 16'hFFFF);
        send_word(CMD_ALLOC, 32'd100, 16'd0);
        send_word(CMD_ALLOC, 32'd200, 16'd0);
        send_word(CMD_ALLOC, 32'd300, 16'd0);
        send_word(CMD_FREE, 32'hFFFF_FFFF, 16'd0);
        send_word(CMD_FREE, 32'd0, 16'hFFFF);
        send_word(CMD_FREE, 32'd0, 16'd2);
        send_word(CMD_FREE, 32'd0, 16'd2);
        send_word(CMD_FREE, 32'd0, 16'd1);
        send_word(CMD_ALLOC, 32'hFFFF_FFFF, 16'd0);
        send_word(CMD_ALLOC, 32'd65236, 16'd0);
        send_word(CMD_FREE, 32'd0, 16'd3);
        send_word(CMD_FREE, 32'd0, 16'd5);
    endtask

    task automatic test_policies();
        for (int p = 0; p < 4; p++) begin
            reg_write(REG_FIT_POLICY, p);
            reg_write(REG_MEM_SIZE, 32'd1000);
            for (int k = 0; k < 5; k++) send_word(CMD_ALLOC, 32'd50 + 50 * k, 16'd0);
            send_word(CMD_FREE, 32'd0, 16'd2);
            send_word(CMD_FREE, 32'd0, 16'd4);
            send_word(CMD_ALLOC, 32'd90, 16'd0);
            send_word(CMD_ALLOC, 32'd600, 16'd0);
        end
    endtask

    task automatic test_memory_extremes();
        reg_write(REG_FIT_POLICY, 32'd0);
        reg_write(REG_MEM_SIZE, 32'd0);
        send_word(CMD_ALLOC, 32'd1, 16'd0);
        reg_write(REG_MEM_SIZE, 32'hFFFF_FFFF);
        send_word(CMD_ALLOC, 32'h8000_0000, 16'd0);
        send_word(CMD_ALLOC, 32'h7FFF_FFFF, 16'd0);
        send_word(CMD_FREE, 32'd0, 16'd1);
        send_word(CMD_FREE, 32'd0, 16'd2);
        reg_write(REG_MEM_SIZE, 32'd1);
        send_word(CMD_ALLOC, 32'd1, 16'd0);
    endtask

    // fill the table to its limit, then an exact fit still succeeds
    task automatic test_table_full();
        reg_write(REG_MEM_SIZE, 32'd1000);
        for (int k = 0; k < 66; k++) send_word(CMD_ALLOC, 32'd1, 16'd0);
        send_word(CMD_ALLOC, 32'd937, 16'd0);
        send_word(CMD_ALLOC, 32'd5, 16'd0);
    endtask

    // runs of small allocate/free pairs walking the id counter
    task automatic test_id_exhaust();
        reg_write(REG_MEM_SIZE, 32'h0001_0000);
        for (int k = 1; k <= 64; k++) begin
            send_word(CMD_ALLOC, 32'd1, 16'd0);
            send_word(CMD_FREE, 32'd0, k[15:0]);
        end
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 120 == 0) begin
                reg_write(REG_FIT_POLICY, $urandom_range(0, 3));
                reg_write(REG_MEM_SIZE, ($urandom_range(0, 9) == 0) ?
                          $urandom : $urandom_range(64, 8192));
            end
            if (k > n - 80) allow_idle = 1'b0;
            case ($urandom_range(0, 9))
                0: send_word(CMD_ALLOC, $urandom, $urandom);
                1: send_word(CMD_FREE, $urandom, $urandom);
                2, 3, 4: free_random_live();
                default: send_word(CMD_ALLOC, $urandom_range(1, 400), $urandom);
            endcase
        end
    endtask

    initial begin
        alloc_model = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_policies();
        test_memory_extremes();
        test_table_full();
        test_id_exhaust();
        test_random(250);
        drain();
        $display("checked %0d result words, %0d with status ok", word_count, ok_count);
        $display("covered all fit policies, size extremes, full table and bad ids");
        if (error_count == 0) begin
            $display("fit_policy_segment_allocator_unit verification clean");
        end else begin
            $display("fit_policy_segment_allocator_unit verification failed");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("fit_policy_segment_allocator_unit verification failed");
        $finish;
    end
endmodule
